FILE: hdl/slxfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_pkg: shared types and constants of the sync/length/XOR frame parser
// Holds the byte role codes, register indexes and the structs that pass
// configuration and per-byte results between the parser modules.
// ----------------------------------------------------------------------------
package slxfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned RoleW  = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Byte role codes carried on the result channel.
  localparam logic [RoleW-1:0] ROLE_HUNT    = 3'd0;
  localparam logic [RoleW-1:0] ROLE_SYNC    = 3'd1;
  localparam logic [RoleW-1:0] ROLE_LEN     = 3'd2;
  localparam logic [RoleW-1:0] ROLE_TYPE    = 3'd3;
  localparam logic [RoleW-1:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [RoleW-1:0] ROLE_CHECK   = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DELIVER_ENABLE = 2'd3;

  localparam logic [LenW-1:0] MAX_LENGTH_RESET = 16'd10240;
  localparam logic [LenW-1:0] MIN_LENGTH       = 16'd2;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [LenW-1:0]  max_length;
    logic             deliver_enable;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic [RoleW-1:0] byte_role;
    logic             frame_start;
    logic             frame_done;
    logic             frame_good;
    logic             deliver;
    logic             length_error;
  } result_t;

endpackage

FILE: hdl/slxfp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_step: frame parser state machine
// Holds the parse phase, remaining payload count, length low byte and
// running XOR, classifies the presented byte and advances on each request.
// ----------------------------------------------------------------------------
module slxfp_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [slxfp_pkg::ByteW-1:0]  byte_in,
  input  slxfp_pkg::cfg_t              cfg,
  output slxfp_pkg::result_t           result
);
  import slxfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC2, PH_LEN_LO, PH_LEN_HI,
    PH_TYPE1, PH_TYPE2, PH_PAYLOAD, PH_CHECK
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [LenW-1:0]  count_r, count_nxt;
  logic [ByteW-1:0] len_lo_r, len_lo_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;

  logic [LenW-1:0]  length;
  logic             is_sync_first;
  logic             len_bad;
  logic [ByteW-1:0] xor_acc;
  logic [LenW-1:0]  count_dec;

  assign length        = {byte_in, len_lo_r};
  assign is_sync_first = (byte_in == cfg.sync_first);
  assign len_bad       = (length > cfg.max_length) || (length < MIN_LENGTH);
  assign xor_acc       = xor_r ^ byte_in;
  assign count_dec     = count_r - LenW'(1);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    len_lo_nxt = len_lo_r;
    xor_nxt    = xor_r;
    result     = '0;
    result.byte_out  = byte_in;
    result.byte_role = ROLE_HUNT;

    unique case (phase_r)
      PH_HUNT, PH_SYNC2, PH_LEN_HI: begin
        if (phase_r == PH_SYNC2 && byte_in == cfg.sync_second) begin
          phase_nxt        = PH_LEN_LO;
          result.byte_role = ROLE_SYNC;
        end else if (phase_r == PH_LEN_HI && !len_bad) begin
          count_nxt        = length - MIN_LENGTH;
          xor_nxt          = '0;
          phase_nxt        = PH_TYPE1;
          result.byte_role = ROLE_LEN;
        end else begin
          // Rejected byte is looked at again as a possible frame start.
          result.length_error = (phase_r == PH_LEN_HI);
          if (is_sync_first) begin
            phase_nxt          = PH_SYNC2;
            result.byte_role   = ROLE_SYNC;
            result.frame_start = 1'b1;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      end
      PH_LEN_LO: begin
        len_lo_nxt       = byte_in;
        phase_nxt        = PH_LEN_HI;
        result.byte_role = ROLE_LEN;
      end
      PH_TYPE1: begin
        xor_nxt          = xor_acc;
        phase_nxt        = PH_TYPE2;
        result.byte_role = ROLE_TYPE;
      end
      PH_TYPE2: begin
        xor_nxt          = xor_acc;
        phase_nxt        = (count_r == '0) ? PH_CHECK : PH_PAYLOAD;
        result.byte_role = ROLE_TYPE;
      end
      PH_PAYLOAD: begin
        xor_nxt          = xor_acc;
        if (count_r != '0) begin
          count_nxt = count_dec;
        end
        if (count_r == '0 || count_dec == '0) begin
          phase_nxt = PH_CHECK;
        end
        result.byte_role = ROLE_PAYLOAD;
      end
      PH_CHECK: begin
        xor_nxt           = xor_acc;
        phase_nxt         = PH_HUNT;
        result.byte_role  = ROLE_CHECK;
        result.frame_done = 1'b1;
        result.frame_good = (xor_acc == '0);
        result.deliver    = (xor_acc == '0) && cfg.deliver_enable;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      count_r  <= '0;
      len_lo_r <= '0;
      xor_r    <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      len_lo_r <= len_lo_nxt;
      xor_r    <= xor_nxt;
    end
  end

endmodule

FILE: hdl/sync_length_xor_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_core: byte-stream frame parser top level
// Each accepted request's result is registered in the output register,
// or in the skid entry when the result side stalls. One byte per cycle
// while in_stall is low. A two-entry result buffer (output register plus
// skid) keeps input open for one extra request while the result side stalls.
// Reset (synchronous, rst_n low) returns the parser to hunting, clears the
// buffers and loads register defaults (max_length 10240, all others zero).
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser_core (
  input  logic                                clk,
  input  logic                                rst_n,

  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [slxfp_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [slxfp_pkg::CfgDataW-1:0]      cfg_wr_data,

  // Input byte channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [slxfp_pkg::ByteW-1:0]         in_byte_in,

  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [slxfp_pkg::ByteW-1:0]         out_byte_out,
  output logic [slxfp_pkg::RoleW-1:0]         out_byte_role,
  output logic                                out_frame_start,
  output logic                                out_frame_done,
  output logic                                out_frame_good,
  output logic                                out_deliver,
  output logic                                out_length_error
);
  import slxfp_pkg::*;

  // Configuration registers. Writes are expected only while the block is idle.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first     <= '0;
      cfg_r.sync_second    <= '0;
      cfg_r.max_length     <= MAX_LENGTH_RESET;
      cfg_r.deliver_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:     cfg_r.sync_first     <= cfg_wr_data[ByteW-1:0];
        REG_SYNC_SECOND:    cfg_r.sync_second    <= cfg_wr_data[ByteW-1:0];
        REG_MAX_LENGTH:     cfg_r.max_length     <= cfg_wr_data[LenW-1:0];
        REG_DELIVER_ENABLE: cfg_r.deliver_enable <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // The input is stalled only when the skid entry is occupied, so the
  // stall is a plain register output and never depends on in_valid.
  logic    skid_valid_r;
  result_t skid_r;
  logic    out_valid_r;
  result_t out_r;
  logic    in_accept;
  logic    out_free;
  result_t step_result;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  // The output register can take new data when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;

  // Parser state advances once per accepted request.
  slxfp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_accept),
    .byte_in (in_byte_in),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  // Control part of the result buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        // No request is accepted while the skid is full; drain it first.
        if (!out_stall) begin
          skid_valid_r <= 1'b0;
          out_valid_r  <= 1'b1;
        end
      end else if (in_accept) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload part of the result buffer; no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_r <= skid_r;
      end
    end else if (in_accept) begin
      if (out_free) begin
        out_r <= step_result;
      end else begin
        skid_r <= step_result;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = out_r.byte_out;
  assign out_byte_role    = out_r.byte_role;
  assign out_frame_start  = out_r.frame_start;
  assign out_frame_done   = out_r.frame_done;
  assign out_frame_good   = out_r.frame_good;
  assign out_deliver      = out_r.deliver;
  assign out_length_error = out_r.length_error;

  // The skid entry is only ever filled behind a held output register.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  // A request accepted into an empty buffer shows up on the next cycle.
  a_accept_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !out_valid_r) |=> out_valid_r)
    else $error("accepted request did not reach the output register");

  // Frame end flags only ride on a check byte.
  a_done_is_check : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_byte_role == ROLE_CHECK))
    else $error("frame_done on a byte that is not a check byte");

  // Delivery requires a good, finished frame.
  a_deliver_good : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_deliver) |-> (out_frame_good && out_frame_done))
    else $error("deliver set without a good finished frame");

endmodule

FILE: verif/slxfp_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_frame_checker: result predictor and comparator for the frame parser
// Watches the configuration port and both byte channels, keeps its own
// copy of the parse state and compares every accepted result in order.
// ----------------------------------------------------------------------------
module slxfp_frame_checker (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_wr_en,
  input  logic [slxfp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [slxfp_pkg::CfgDataW-1:0] cfg_wr_data,

  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [slxfp_pkg::ByteW-1:0]   in_byte_in,

  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [slxfp_pkg::ByteW-1:0]   out_byte_out,
  input  logic [slxfp_pkg::RoleW-1:0]   out_byte_role,
  input  logic                          out_frame_start,
  input  logic                          out_frame_done,
  input  logic                          out_frame_good,
  input  logic                          out_deliver,
  input  logic                          out_length_error,

  output int unsigned                   fail_count,
  output int unsigned                   pending_count,
  output int unsigned                   checked_count,
  output int unsigned                   delivered_count
);
  import slxfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC2, PH_LEN_LO, PH_LEN_HI, PH_TYPE1, PH_TYPE2, PH_PAYLOAD, PH_CHECK
  } parse_phase_t;

  // Shadow registers and parse state.
  logic [ByteW-1:0] sync_first_q;
  logic [ByteW-1:0] sync_second_q;
  logic [LenW-1:0]  max_length_q;
  logic             deliver_enable_q;
  parse_phase_t     phase;
  logic [LenW-1:0]  remaining;
  logic [ByteW-1:0] len_low;
  logic [ByteW-1:0] check_xor;

  result_t     expected_results [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned delivered;

  assign fail_count = errors;

  // A byte seen while hunting: it either opens a candidate frame or is dropped.
  function automatic void rehunt(input logic [ByteW-1:0] b, inout result_t r);
    if (b == sync_first_q) begin
      phase         = PH_SYNC2;
      r.byte_role   = ROLE_SYNC;
      r.frame_start = 1'b1;
    end else begin
      phase       = PH_HUNT;
      r.byte_role = ROLE_HUNT;
    end
  endfunction

  function automatic result_t parse_byte(input logic [ByteW-1:0] b);
    result_t         r;
    logic [LenW-1:0] len;
    r          = '0;
    r.byte_out = b;
    case (phase)
      PH_HUNT: rehunt(b, r);
      PH_SYNC2: begin
        if (b == sync_second_q) begin
          phase       = PH_LEN_LO;
          r.byte_role = ROLE_SYNC;
        end else begin
          rehunt(b, r);
        end
      end
      PH_LEN_LO: begin
        len_low     = b;
        phase       = PH_LEN_HI;
        r.byte_role = ROLE_LEN;
      end
      PH_LEN_HI: begin
        len = {b, len_low};
        if (len > max_length_q || len < MIN_LENGTH) begin
          r.length_error = 1'b1;
          rehunt(b, r);
        end else begin
          remaining   = len - MIN_LENGTH;
          check_xor   = '0;
          phase       = PH_TYPE1;
          r.byte_role = ROLE_LEN;
        end
      end
      PH_TYPE1: begin
        check_xor   = check_xor ^ b;
        phase       = PH_TYPE2;
        r.byte_role = ROLE_TYPE;
      end
      PH_TYPE2: begin
        check_xor   = check_xor ^ b;
        phase       = (remaining == '0) ? PH_CHECK : PH_PAYLOAD;
        r.byte_role = ROLE_TYPE;
      end
      PH_PAYLOAD: begin
        check_xor = check_xor ^ b;
        if (remaining != '0) remaining = remaining - LenW'(1);
        if (remaining == '0) phase = PH_CHECK;
        r.byte_role = ROLE_PAYLOAD;
      end
      default: begin
        check_xor     = check_xor ^ b;
        r.frame_done  = 1'b1;
        r.frame_good  = (check_xor == '0);
        r.deliver     = r.frame_good & deliver_enable_q;
        phase         = PH_HUNT;
        r.byte_role   = ROLE_CHECK;
      end
    endcase
    return r;
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("byte=%02h role=%0d start=%b done=%b good=%b deliver=%b len_err=%b",
                     r.byte_out, r.byte_role, r.frame_start, r.frame_done, r.frame_good,
                     r.deliver, r.length_error);
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      sync_first_q     = '0;
      sync_second_q    = '0;
      max_length_q     = MAX_LENGTH_RESET;
      deliver_enable_q = 1'b0;
      phase            = PH_HUNT;
      remaining        = '0;
      len_low          = '0;
      check_xor        = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SYNC_FIRST:     sync_first_q     = cfg_wr_data[ByteW-1:0];
          REG_SYNC_SECOND:    sync_second_q    = cfg_wr_data[ByteW-1:0];
          REG_MAX_LENGTH:     max_length_q     = cfg_wr_data[LenW-1:0];
          REG_DELIVER_ENABLE: deliver_enable_q = cfg_wr_data[0];
          default: ;
        endcase
      end

      // The result leaving now belongs to an older request, so compare first.
      if (out_valid && !out_stall) begin
        got.byte_out     = out_byte_out;
        got.byte_role    = out_byte_role;
        got.frame_start  = out_frame_start;
        got.frame_done   = out_frame_done;
        got.frame_good   = out_frame_good;
        got.deliver      = out_deliver;
        got.length_error = out_length_error;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result with no request pending: %s", $time, describe(got));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.deliver === 1'b1) delivered++;
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] result %0d differs", $time, checked);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end

      // New predictions go to the tail of the queue.
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), parse_byte(in_byte_in));
    end
    pending_count   <= expected_results.size();
    checked_count   <= checked;
    delivered_count <= delivered;
  end

  initial begin
    errors          = 0;
    checked         = 0;
    delivered       = 0;
    pending_count   = 0;
    checked_count   = 0;
    delivered_count = 0;
  end

endmodule

FILE: verif/tb_sync_length_xor_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_length_xor_frame_parser_core: stimulus and verdict for the parser
// Streams a short hand-built byte sequence and then about 1600 random bytes,
// mostly whole frames with random content, across several register settings.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sync_length_xor_frame_parser_core;
  import slxfp_pkg::*;

  // The slowest legal run stays far below this limit.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned NumPhases = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [ByteW-1:0]    in_byte_in;
  logic                out_valid;
  logic                out_stall;
  logic [ByteW-1:0]    out_byte_out;
  logic [RoleW-1:0]    out_byte_role;
  logic                out_frame_start;
  logic                out_frame_done;
  logic                out_frame_good;
  logic                out_deliver;
  logic                out_length_error;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned delivered_count;

  // The register values currently loaded; frames are built from these.
  logic [ByteW-1:0] cur_sync_first;
  logic [ByteW-1:0] cur_sync_second;
  int unsigned      cur_max_length;

  // Idle controls: gap_mode opens random holes between requests on the
  // input side, stall_mode lets the result side push back in bursts.
  bit gap_mode;
  bit stall_mode;

  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned n_intact;
  int unsigned n_corrupt;
  int unsigned n_len_abort;
  int unsigned n_sync_break;

  sync_length_xor_frame_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_byte_role    (out_byte_role),
    .out_frame_start  (out_frame_start),
    .out_frame_done   (out_frame_done),
    .out_frame_good   (out_frame_good),
    .out_deliver      (out_deliver),
    .out_length_error (out_length_error)
  );

  slxfp_frame_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_byte_role    (out_byte_role),
    .out_frame_start  (out_frame_start),
    .out_frame_done   (out_frame_done),
    .out_frame_good   (out_frame_good),
    .out_deliver      (out_deliver),
    .out_length_error (out_length_error),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count),
    .delivered_count  (delivered_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result-side back-pressure. With stall_mode set, stall rises in random bursts;
  // with stall_mode clear the result side takes every result at once.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_mode && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one byte and hold it until the block takes the request. valid is
  // only lowered for a gap, never in the step in which it is raised again.
  task automatic send_byte(input logic [ByteW-1:0] value);
    if (gap_mode && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Write all four registers back to back. The block must be idle here.
  task automatic load_registers(input logic [ByteW-1:0] s1, input logic [ByteW-1:0] s2,
                                input logic [LenW-1:0] max_len, input logic den);
    // The upper data bits of the narrow registers carry noise; they must be ignored.
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_SYNC_FIRST;
    cfg_wr_data <= {8'($urandom_range(0, 255)), s1};
    @(posedge clk);
    cfg_index   <= REG_SYNC_SECOND;
    cfg_wr_data <= {8'($urandom_range(0, 255)), s2};
    @(posedge clk);
    cfg_index   <= REG_MAX_LENGTH;
    cfg_wr_data <= max_len;
    @(posedge clk);
    cfg_index   <= REG_DELIVER_ENABLE;
    cfg_wr_data <= {15'($urandom_range(0, 32767)), den};
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    cur_sync_first  = s1;
    cur_sync_second = s2;
    cur_max_length  = 32'(max_len);
  endtask

  // Stop offering requests and wait until every result has come back, then
  // let the block settle so that it is truly idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  // Sync word, length field and, with_body set, the type bytes, payload and
  // check byte. The length counts type bytes plus payload, so len data
  // bytes follow the header. A corrupted frame gets a nonzero XOR residue.
  task automatic send_frame(input int unsigned len, input bit corrupt, input bit with_body);
    logic [LenW-1:0]  len_field;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] folded;
    len_field = len[LenW-1:0];
    folded    = '0;
    send_byte(cur_sync_first);
    send_byte(cur_sync_second);
    send_byte(len_field[7:0]);
    send_byte(len_field[15:8]);
    if (with_body) begin
      repeat (len) begin
        data   = 8'($urandom_range(0, 255));
        folded = folded ^ data;
        send_byte(data);
      end
      send_byte(corrupt ? (folded ^ 8'($urandom_range(1, 255))) : folded);
    end
  endtask

  // Mostly short frames to keep the run fast; now and then a longer one, and
  // sometimes exactly the limit so the inclusive bound gets exercised.
  function automatic int unsigned pick_length();
    int unsigned cap;
    int unsigned roll;
    cap  = (cur_max_length < 300) ? cur_max_length : 300;
    roll = $urandom_range(0, 15);
    if (roll == 0 && cur_max_length <= 300) return cur_max_length;
    if (roll <= 1) return $urandom_range(2, cap);
    return $urandom_range(2, (cap < 14) ? cap : 14);
  endfunction

  // One random unit of traffic: mostly well-formed frames with random
  // content, then corrupted check bytes, bad lengths, broken sync words and
  // stray bytes on the line.
  task automatic send_random_unit();
    int unsigned roll;
    int unsigned len;
    logic [ByteW-1:0] junk;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      send_frame(pick_length(), 1'b0, 1'b1);
      n_intact++;
    end else if (roll < 70) begin
      send_frame(pick_length(), 1'b1, 1'b1);
      n_corrupt++;
    end else if (roll < 80) begin
      // Mostly too long when the limit leaves room above it, otherwise too short.
      if (cur_max_length < 65535 && $urandom_range(0, 2) != 0)
        len = $urandom_range(cur_max_length + 1, 65535);
      else
        len = $urandom_range(0, 1);
      send_frame(len, 1'b0, 1'b0);
      n_len_abort++;
    end else if (roll < 90) begin
      // Broken sync word; half the time the bad byte is another first sync byte.
      send_byte(cur_sync_first);
      if ($urandom_range(0, 1) == 0) begin
        send_byte(cur_sync_first);
      end else begin
        junk = 8'($urandom_range(0, 255));
        send_byte(junk);
      end
      n_sync_break++;
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] directed [$];
    logic [ByteW-1:0] s1;
    logic [ByteW-1:0] s2;
    logic [LenW-1:0]  max_len;
    logic             den;
    int unsigned      phase_end;

    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_SYNC_FIRST;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_byte_in   = '0;
    gap_mode     = 1'b1;
    stall_mode   = 1'b1;
    cycle_count  = 0;
    bytes_sent   = 0;
    n_intact     = 0;
    n_corrupt    = 0;
    n_len_abort  = 0;
    n_sync_break = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with sync word AA 55, a limit of 16 and delivery on.
    load_registers(8'hAA, 8'h55, 16'd16, 1'b1);
    directed = '{
      // Sync byte followed by a wrong second byte: back to hunting.
      8'hAA, 8'h00,
      // A repeated first sync byte restarts the candidate, then a good
      // frame with no payload whose check byte equals the first sync byte.
      8'hAA, 8'hAA, 8'h55, 8'h02, 8'h00, 8'hA0, 8'h0A, 8'hAA,
      // Length above the limit; its high byte opens the next candidate.
      8'hAA, 8'h55, 8'hFF, 8'hAA,
      // Length of one is too short; the high byte is then a hunting byte.
      8'h55, 8'h01, 8'h00,
      // Frame with payload and a wrong check byte.
      8'hAA, 8'h55, 8'h03, 8'h00, 8'hF0, 8'h0F, 8'h80, 8'h7E
    };
    foreach (directed[i]) send_byte(directed[i]);
    drain_results();

    // Random part, split into phases with their own register settings. The
    // first phases cover the extremes: the smallest limit (only zero-payload
    // frames pass), the largest limit, all-zero and all-one sync bytes, and
    // a sync word made of one repeated byte.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin s1 = 8'h00; s2 = 8'hFF; max_len = 16'd2;     den = 1'b1; end
        1: begin s1 = 8'hFF; s2 = 8'h00; max_len = 16'hFFFF;  den = 1'b0; end
        2: begin
          s1 = 8'($urandom_range(0, 255)); s2 = ~s1;
          max_len = 16'($urandom_range(2, 40)); den = 1'b1;
        end
        3: begin
          s1 = 8'($urandom_range(0, 255)); s2 = s1;
          max_len = 16'd300; den = 1'b1;
        end
        default: begin
          s1 = 8'($urandom_range(0, 255));
          s2 = 8'($urandom_range(0, 255));
          max_len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(2, 64))
                                                : 16'($urandom_range(2, 65535));
          den = 1'($urandom_range(0, 1));
        end
      endcase
      load_registers(s1, s2, max_len, den);

      // Rotate through both sides idling, one side only and none at all;
      // the final phase runs at full rate with no idling anywhere.
      gap_mode   = (p % 4 == 0) || (p % 4 == 1);
      stall_mode = (p % 4 == 0) || (p % 4 == 2);
      if (p == NumPhases - 1) begin
        gap_mode   = 1'b0;
        stall_mode = 1'b0;
      end

      phase_end = bytes_sent + RandomBytes / NumPhases;
      while (bytes_sent < phase_end) send_random_unit();
      drain_results();
    end

    $display("Sent %0d bytes: %0d intact frames, %0d corrupted, %0d bad lengths, %0d sync breaks.",
             bytes_sent, n_intact, n_corrupt, n_len_abort, n_sync_break);
    $display("Checked %0d results over %0d register settings; %0d frames flagged for delivery.",
             checked_count, NumPhases + 1, delivered_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", fail_count, pending_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
